>>> design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue with remove.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int ID_W             = 16;
    localparam int PRIO_W           = 16;
    localparam int COUNT_W          = 5;
    localparam int CAPACITY_DEFAULT = 16;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_REMOVE = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    // carried left to right along the row
    typedef struct packed {
        logic                     stay;
        logic                     found;
        logic signed [PRIO_W-1:0] sel_prio;
    } t_link;

    // broadcast to every cell
    typedef struct packed {
        logic                     ins_en;
        logic                     rem_en;
        logic                     pop_en;
        logic [ID_W-1:0]          key_id;
        logic signed [PRIO_W-1:0] key_prio;
    } t_cell_cmd;

endpackage

`default_nettype wire

>>> design/spq_if.sv
// ----------------------------------------------------------------------------
// spq_cmd_if / spq_rsp_if
// Valid/ready channels for queue commands and their responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        func;
    logic [spq_pkg::ID_W-1:0]          task_id;
    logic signed [spq_pkg::PRIO_W-1:0] task_priority;

    modport source (output valid, func, task_id, task_priority, input ready);
    modport sink   (input valid, func, task_id, task_priority, output ready);
endinterface

interface spq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [spq_pkg::ID_W-1:0]          removed_id;
    logic signed [spq_pkg::PRIO_W-1:0] removed_priority;
    logic [spq_pkg::COUNT_W-1:0]       entry_count;

    modport source (output valid, status, removed_id, removed_priority, entry_count,
                    input ready);
    modport sink   (input valid, status, removed_id, removed_priority, entry_count,
                    output ready);
endinterface

`default_nettype wire

>>> design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, shifts right on insert and
// left on removal, and passes compare results to its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire                     i_clk,
    input  wire                     i_valid,
    input  spq_pkg::t_cell_cmd      i_cmd,
    input  spq_pkg::t_entry         i_left_ent,
    input  spq_pkg::t_entry         i_right_ent,
    input  spq_pkg::t_link          i_left_link,
    output spq_pkg::t_entry         o_ent,
    output spq_pkg::t_link          o_link
);

    spq_pkg::t_entry r_ent;
    spq_pkg::t_entry n_ent;
    logic            hit;

    always_comb begin
        hit             = i_cmd.rem_en && i_valid && (r_ent.id == i_cmd.key_id);
        o_link.stay     = i_valid && (r_ent.prio >= i_cmd.key_prio);
        o_link.found    = i_left_link.found || hit || i_cmd.pop_en;
        if (i_left_link.found) begin
            o_link.sel_prio = i_left_link.sel_prio;
        end else if (hit) begin
            o_link.sel_prio = r_ent.prio;
        end else begin
            o_link.sel_prio = '0;
        end

        n_ent = r_ent;
        if (i_cmd.ins_en) begin
            if (o_link.stay) begin
                n_ent = r_ent;
            end else if (i_left_link.stay) begin
                n_ent.id   = i_cmd.key_id;
                n_ent.prio = i_cmd.key_prio;
            end else begin
                n_ent = i_left_ent;
            end
        end else if (o_link.found) begin
            n_ent = i_right_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

>>> design/sorted_priority_queue_with_remove.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_remove
// Bounded priority queue kept sorted by descending priority in a row of
// cells; supports insert, pop of the head and remove by id.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  i_cmd    in   func, task_id, task_priority
//  o_rsp    out  status, removed_id, removed_priority, entry_count
//
//  each transaction registers the command first and then executes: every cell
//  compares and shifts at once and the response register loads
//  the execute cycle waits while a response is still held on o_rsp
//  reset clears the entry count and the control flags; cells are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_with_remove #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    spq_cmd_if.sink    i_cmd,
    spq_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                              r_busy;
    logic [1:0]                        r_func;
    logic [spq_pkg::ID_W-1:0]          r_id;
    logic signed [spq_pkg::PRIO_W-1:0] r_prio;
    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;

    logic                              r_out_valid;
    logic [1:0]                        r_status;
    logic [spq_pkg::ID_W-1:0]          r_rid;
    logic signed [spq_pkg::PRIO_W-1:0] r_rprio;
    logic [1:0]                        n_status;
    logic [spq_pkg::ID_W-1:0]          n_rid;
    logic signed [spq_pkg::PRIO_W-1:0] n_rprio;

    logic               exec;
    logic               empty;
    logic               full;
    spq_pkg::t_cell_cmd cmd;
    logic [CAPACITY-1:0] valid;
    spq_pkg::t_entry    ent  [CAPACITY];
    spq_pkg::t_link     link [CAPACITY+1];

    assign i_cmd.ready = i_rst_n && !r_busy;
    assign exec        = r_busy && (!r_out_valid || o_rsp.ready);
    assign empty       = (r_count == '0);
    assign full        = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        cmd.ins_en   = exec && (r_func == spq_pkg::FUNC_INSERT) && !full;
        cmd.rem_en   = exec && (r_func == spq_pkg::FUNC_REMOVE) && !empty;
        cmd.pop_en   = exec && (r_func == spq_pkg::FUNC_POP) && !empty;
        cmd.key_id   = r_id;
        cmd.key_prio = r_prio;
    end

    assign link[0] = '{stay: 1'b1, found: 1'b0, sel_prio: '0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_entry left_ent;
        spq_pkg::t_entry right_ent;
        assign valid[g] = (CNT_W'(g) < r_count);
        if (g == 0) begin : g_first
            assign left_ent = '0;
        end else begin : g_mid
            assign left_ent = ent[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_ent = '0;
        end else begin : g_inner
            assign right_ent = ent[g+1];
        end
        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_valid     (valid[g]),
            .i_cmd       (cmd),
            .i_left_ent  (left_ent),
            .i_right_ent (right_ent),
            .i_left_link (link[g]),
            .o_ent       (ent[g]),
            .o_link      (link[g+1])
        );
    end

    always_comb begin
        n_status = spq_pkg::ST_OK;
        n_rid    = '0;
        n_rprio  = '0;
        n_count  = r_count;
        unique case (r_func)
            spq_pkg::FUNC_INSERT: begin
                if (full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            spq_pkg::FUNC_POP: begin
                if (empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_rid   = ent[0].id;
                    n_rprio = ent[0].prio;
                    n_count = r_count - CNT_W'(1);
                end
            end
            spq_pkg::FUNC_REMOVE: begin
                if (empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else if (!link[CAPACITY].found) begin
                    n_status = spq_pkg::ST_NOT_FOUND;
                end else begin
                    n_rid   = r_id;
                    n_rprio = link[CAPACITY].sel_prio;
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = spq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_busy <= 1'b1;
            end else if (exec) begin
                r_busy <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_func <= i_cmd.func;
            r_id   <= i_cmd.task_id;
            r_prio <= i_cmd.task_priority;
        end
        if (exec) begin
            r_status <= n_status;
            r_rid    <= n_rid;
            r_rprio  <= n_rprio;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_status;
    assign o_rsp.removed_id       = r_rid;
    assign o_rsp.removed_priority = r_rprio;
    assign o_rsp.entry_count      = spq_pkg::COUNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> r_busy)
        else $error("accepted command not held for execution");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec |=> $stable(r_count))
        else $error("entry count changed outside execution");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != spq_pkg::ST_OK)) |-> (r_rid == '0 && r_rprio == '0))
        else $error("error response carries a removed entry");

endmodule

`default_nettype wire
